// ----- rtl/core/sip_pkg.sv -----
`timescale 1ns / 1ps

package sip_pkg;

  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,
    JOB_PANEL = 2'd1,
    JOB_CORR  = 2'd2
  } job_kind_e;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FEW     = 2'd1;
  localparam logic [1:0] STATUS_SPACING = 2'd2;
  localparam logic [1:0] STATUS_SAT     = 2'd3;

  localparam int unsigned INTEGRAL_WIDTH = 64;

endpackage

// ----- rtl/core/sip_front.sv -----
`timescale 1ns / 1ps

module sip_front #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned OW         = 36,
  parameter type         job_t      = logic
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [WORD_WIDTH-1:0] sample_x_i,
  input  logic signed [WORD_WIDTH-1:0] sample_f_i,
  input  logic                         last_point_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output job_t                         job_o
);

  logic signed [WORD_WIDTH-1:0] px0_q, px0_d, px1_q, px1_d;
  logic signed [WORD_WIDTH-1:0] pf0_q, pf0_d, pf1_q, pf1_d;
  logic [1:0]                   seen_q, seen_d;
  logic                         odd_q, odd_d;
  logic                         err_q, err_d;

  logic                         accept;
  logic signed [WORD_WIDTH:0]   dx, dold;
  logic signed [OW-1:0]         h_new, h_old, s, fx, f0, f1;
  logic                         err_n, panel, corr;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i & job_ready_i;

  assign dx    = (WORD_WIDTH+1)'(sample_x_i) - (WORD_WIDTH+1)'(px1_q);
  assign dold  = (WORD_WIDTH+1)'(px1_q) - (WORD_WIDTH+1)'(px0_q);
  assign h_new = OW'(dx);
  assign h_old = OW'(dold);
  assign s     = h_new + h_old;
  assign fx    = OW'(sample_f_i);
  assign f0    = OW'(pf0_q);
  assign f1    = OW'(pf1_q);

  assign err_n = err_q | ((seen_q != 2'd0) & (dx <= 0));
  assign panel = !err_n && (seen_q >= 2'd2) && !odd_q;
  assign corr  = !err_n && (seen_q == 2'd3) && odd_q && last_point_i;

  assign job_valid_o = in_valid_i & (panel | corr | last_point_i);

  always_comb begin
    job_o      = '0;
    job_o.last = last_point_i;
    if (seen_q < 2'd2) begin
      job_o.code = sip_pkg::STATUS_FEW;
    end else if (err_n) begin
      job_o.code = sip_pkg::STATUS_SPACING;
    end else begin
      job_o.code = sip_pkg::STATUS_OK;
    end
    if (panel) begin
      job_o.kind = sip_pkg::JOB_PANEL;
      job_o.a1   = (h_old <<< 1) - h_new;
      job_o.b1   = h_new;
      job_o.fa   = f0;
      job_o.a3   = s;
      job_o.b3   = s;
      job_o.fb   = f1;
      job_o.a5   = (h_new <<< 1) - h_old;
      job_o.b5   = h_old;
      job_o.fc   = fx;
      job_o.csub = 1'b0;
      job_o.b7   = s;
      job_o.a8   = (h_old <<< 2) + (h_old <<< 1);
      job_o.b8   = h_new;
    end else if (corr) begin
      job_o.kind = sip_pkg::JOB_CORR;
      job_o.a1   = (h_new <<< 1) + (h_old <<< 1) + h_old;
      job_o.b1   = h_old;
      job_o.fa   = fx;
      job_o.a3   = h_new + (h_old <<< 1) + h_old;
      job_o.b3   = s;
      job_o.fb   = f1;
      job_o.a5   = h_new;
      job_o.b5   = h_new;
      job_o.fc   = f0;
      job_o.csub = 1'b1;
      job_o.b7   = h_new;
      job_o.a8   = (h_old <<< 2) + (h_old <<< 1);
      job_o.b8   = s;
    end else begin
      job_o.kind = sip_pkg::JOB_NONE;
    end
  end

  always_comb begin
    px0_d  = px0_q;
    px1_d  = px1_q;
    pf0_d  = pf0_q;
    pf1_d  = pf1_q;
    seen_d = seen_q;
    odd_d  = odd_q;
    err_d  = err_q;
    if (accept) begin
      if (last_point_i) begin
        px0_d  = '0;
        px1_d  = '0;
        pf0_d  = '0;
        pf1_d  = '0;
        seen_d = 2'd0;
        odd_d  = 1'b0;
        err_d  = 1'b0;
      end else begin
        px0_d  = px1_q;
        px1_d  = sample_x_i;
        pf0_d  = pf1_q;
        pf1_d  = sample_f_i;
        seen_d = (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;
        odd_d  = ~odd_q;
        err_d  = err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px0_q  <= '0;
      px1_q  <= '0;
      pf0_q  <= '0;
      pf1_q  <= '0;
      seen_q <= 2'd0;
      odd_q  <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      px0_q  <= px0_d;
      px1_q  <= px1_d;
      pf0_q  <= pf0_d;
      pf1_q  <= pf1_d;
      seen_q <= seen_d;
      odd_q  <= odd_d;
      err_q  <= err_d;
    end
  end

endmodule

// ----- rtl/core/sip_fifo.sv -----
`timescale 1ns / 1ps

module sip_fifo #(
  parameter type job_t = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/core/sip_back.sv -----
`timescale 1ns / 1ps

module sip_back #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned SUM_WIDTH  = 64,
  parameter int unsigned OW         = 36,
  parameter type         job_t      = logic
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      job_valid_i,
  output logic                                      job_ready_o,
  input  job_t                                      job_i,
  output logic                                      res_valid_o,
  input  logic                                      res_ready_i,
  output logic signed [sip_pkg::INTEGRAL_WIDTH-1:0] integral_o,
  output logic [1:0]                                status_o
);

  localparam int unsigned NW = 4 * WORD_WIDTH + 6;
  localparam int unsigned DW = 2 * WORD_WIDTH + 4;
  localparam int unsigned CW = $clog2(NW);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e                      state_q, state_d;
  job_t                        job_q, job_d;
  logic signed [NW-1:0]        acc_q, acc_d, t_q, t_d, p_q, p_d, ma_q, ma_d;
  logic [OW-1:0]               mb_q, mb_d;
  logic [DW-1:0]               d_q, d_d, rem_q, rem_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [2:0]                  step_q, step_d;
  logic                        neg_q, neg_d;
  logic signed [SUM_WIDTH-1:0] sum_q, sum_d;
  logic                        sat_q, sat_d;
  logic                        out_valid_q, out_valid_d;
  logic signed [sip_pkg::INTEGRAL_WIDTH-1:0] out_int_q, out_int_d;
  logic [1:0]                  out_st_q, out_st_d;

  logic signed [NW-1:0]        a_op, p_next, qf, qs;
  logic signed [OW-1:0]        b_op;
  logic                        mul_last;
  logic [DW:0]                 rem2;
  logic                        ge;
  logic signed [NW:0]          sumw;
  logic                        fits;

  assign job_ready_o = (state_q == ST_IDLE) && (!job_i.last || !out_valid_q);
  assign res_valid_o = out_valid_q;
  assign integral_o  = out_int_q;
  assign status_o    = out_st_q;

  always_comb begin
    case (step_q)
      3'd0: begin a_op = NW'(job_q.a1); b_op = job_q.b1; end
      3'd1: begin a_op = t_q;           b_op = job_q.fa; end
      3'd2: begin a_op = NW'(job_q.a3); b_op = job_q.b3; end
      3'd3: begin a_op = t_q;           b_op = job_q.fb; end
      3'd4: begin a_op = NW'(job_q.a5); b_op = job_q.b5; end
      3'd5: begin a_op = t_q;           b_op = job_q.fc; end
      3'd6: begin a_op = acc_q;         b_op = job_q.b7; end
      default: begin a_op = NW'(job_q.a8); b_op = job_q.b8; end
    endcase
  end

  // The top bit of the multiplier carries negative weight.
  assign mul_last = (cnt_q == CW'(OW - 1));
  always_comb begin
    p_next = p_q;
    if (mb_q[0]) begin
      p_next = mul_last ? p_q - ma_q : p_q + ma_q;
    end
  end

  assign rem2 = {rem_q, acc_q[NW-1]};
  assign ge   = (rem2 >= {1'b0, d_q});

  assign qf   = neg_q ? ~acc_q : acc_q;
  assign qs   = qf >>> FRAC_BITS;
  assign sumw = (NW+1)'(sum_q) + (NW+1)'(qs);
  assign fits = (sumw[NW:SUM_WIDTH-1] == '0 || sumw[NW:SUM_WIDTH-1] == '1);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    acc_d       = acc_q;
    t_d         = t_q;
    p_d         = p_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    d_d         = d_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    neg_d       = neg_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    out_int_d   = out_int_q;
    out_st_d    = out_st_q;
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i && job_ready_o) begin
          job_d  = job_i;
          step_d = 3'd0;
          state_d = (job_i.kind == sip_pkg::JOB_NONE) ? ST_FIN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        ma_d    = a_op;
        mb_d    = b_op;
        p_d     = '0;
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        p_d   = p_next;
        ma_d  = ma_q <<< 1;
        mb_d  = mb_q >> 1;
        cnt_d = cnt_q + CW'(1);
        if (mul_last) begin
          step_d  = step_q + 3'd1;
          state_d = ST_LOAD;
          case (step_q)
            3'd0, 3'd2, 3'd4: t_d = p_next;
            3'd1, 3'd6:       acc_d = p_next;
            3'd3:             acc_d = acc_q + p_next;
            3'd5:             acc_d = job_q.csub ? acc_q - p_next : acc_q + p_next;
            default: begin
              d_d     = p_next[DW-1:0];
              neg_d   = acc_q[NW-1];
              acc_d   = acc_q[NW-1] ? ~acc_q : acc_q;
              rem_d   = '0;
              cnt_d   = '0;
              state_d = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d = ge ? DW'(rem2 - {1'b0, d_q}) : rem2[DW-1:0];
        acc_d = {acc_q[NW-2:0], ge};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (fits) begin
          sum_d = sumw[SUM_WIDTH-1:0];
        end else begin
          sum_d = sumw[NW] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
          sat_d = 1'b1;
        end
        state_d = job_q.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        out_valid_d = 1'b1;
        if (job_q.code != sip_pkg::STATUS_OK) begin
          out_int_d = '0;
          out_st_d  = job_q.code;
        end else begin
          out_int_d = sip_pkg::INTEGRAL_WIDTH'(sum_q);
          out_st_d  = sat_q ? sip_pkg::STATUS_SAT : sip_pkg::STATUS_OK;
        end
        sum_d   = '0;
        sat_d   = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    acc_q     <= acc_d;
    t_q       <= t_d;
    p_q       <= p_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    d_q       <= d_d;
    rem_q     <= rem_d;
    neg_q     <= neg_d;
    out_int_q <= out_int_d;
    out_st_q  <= out_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      step_q      <= 3'd0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/simpson_integrator_nonuniform_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)             tuser     tlast
// s_axis    in         sample_x, sample_f, zero pad   -         last_point
// m_axis    out        integral                       status    -
//
// A panel or end correction holds the back end through the bit-serial multiplier and the
// one-bit-per-cycle divider, and through ST_FIN as well when it closes the series; points
// that add no panel pass the front combinationally.
// A two-entry queue lets the front take points while the back end computes.
// Reset clears the series state and the running sum at once.
// A stalled result holds the back end only when the next queued job is a last point.

module simpson_integrator_nonuniform_top #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned SUM_WIDTH  = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_x, sample_f, zero pad
  input  logic [((2*WORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // integral
  output logic [sip_pkg::INTEGRAL_WIDTH-1:0]   m_axis_tdata,
  // status
  output logic [1:0]                           m_axis_tuser
);

  localparam int unsigned OW = WORD_WIDTH + 4;

  typedef struct packed {
    sip_pkg::job_kind_e   kind;
    logic                 last;
    logic [1:0]           code;
    logic                 csub;
    logic signed [OW-1:0] a1;
    logic signed [OW-1:0] b1;
    logic signed [OW-1:0] fa;
    logic signed [OW-1:0] a3;
    logic signed [OW-1:0] b3;
    logic signed [OW-1:0] fb;
    logic signed [OW-1:0] a5;
    logic signed [OW-1:0] b5;
    logic signed [OW-1:0] fc;
    logic signed [OW-1:0] b7;
    logic signed [OW-1:0] a8;
    logic signed [OW-1:0] b8;
  } job_t;

  job_t job_in, job_out;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [sip_pkg::INTEGRAL_WIDTH-1:0] integral;

  sip_front #(
    .WORD_WIDTH(WORD_WIDTH),
    .OW        (OW),
    .job_t     (job_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_x_i  (s_axis_tdata[WORD_WIDTH-1:0]),
    .sample_f_i  (s_axis_tdata[2*WORD_WIDTH-1:WORD_WIDTH]),
    .last_point_i(s_axis_tlast),
    .job_valid_o (in_valid),
    .job_ready_i (in_ready),
    .job_o       (job_in)
  );

  sip_fifo #(
    .job_t(job_t)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(in_valid),
    .wr_ready_o(in_ready),
    .wr_data_i (job_in),
    .rd_valid_o(out_valid),
    .rd_ready_i(out_ready),
    .rd_data_o (job_out)
  );

  sip_back #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .SUM_WIDTH (SUM_WIDTH),
    .OW        (OW),
    .job_t     (job_t)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(out_valid),
    .job_ready_o(out_ready),
    .job_i      (job_out),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .integral_o (integral),
    .status_o   (m_axis_tuser)
  );

  assign m_axis_tdata = integral;

endmodule

// ----- verif/simpson_checker.sv -----
`timescale 1ns / 1ps

module simpson_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [63:0] integral;
    logic [1:0]  status;
  } integral_result_t;

  localparam wide_t SUM_HI = 256'sh7FFF_FFFF_FFFF_FFFF;
  localparam wide_t SUM_LO = -SUM_HI - 1;
  localparam wide_t FIX_SCALE = 256'sd65536;

  integral_result_t expected_q[$];

  logic signed [31:0] x_hist[2] = '{32'sd0, 32'sd0};
  logic signed [31:0] f_hist[2] = '{32'sd0, 32'sd0};
  logic [1:0]         n_seen = 2'd0;
  logic               odd_pt = 1'b0;
  logic signed [63:0] integ_sum = 64'sd0;
  logic [1:0]         err_code = sip_pkg::STATUS_OK;
  int                 fail_count = 0;
  int                 n_pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = n_pending;

  function automatic wide_t floor_div(wide_t n, wide_t d);
    if (n < 0) return ~((~n) / d);
    return n / d;
  endfunction

  task automatic clear_series();
    x_hist[0] = '0; x_hist[1] = '0;
    f_hist[0] = '0; f_hist[1] = '0;
    n_seen = '0; odd_pt = 1'b0; integ_sum = '0; err_code = sip_pkg::STATUS_OK;
  endtask

  task automatic add_to_sum(wide_t delta);
    wide_t s;
    s = wide_t'(integ_sum) + delta;
    if (s > SUM_HI || s < SUM_LO) begin
      s = (s < 0) ? SUM_LO : SUM_HI;
      if (err_code == sip_pkg::STATUS_OK) err_code = sip_pkg::STATUS_SAT;
    end
    integ_sum = s[63:0];
  endtask

  task automatic predict_point(logic signed [31:0] x, logic signed [31:0] f, logic last);
    logic [1:0] seen;
    wide_t h1, h2, s, n, fx, f0, f1;
    integral_result_t r;
    seen = n_seen;
    fx = f; f0 = f_hist[0]; f1 = f_hist[1];
    if (seen >= 1 && err_code != sip_pkg::STATUS_SPACING &&
        (wide_t'(x) - wide_t'(x_hist[1])) <= 0)
      err_code = sip_pkg::STATUS_SPACING;
    if (err_code != sip_pkg::STATUS_SPACING && seen >= 2) begin
      if (!odd_pt) begin
        h1 = wide_t'(x_hist[1]) - wide_t'(x_hist[0]);
        h2 = wide_t'(x) - wide_t'(x_hist[1]);
        s = h1 + h2;
        n = 2 * h1 * h2 * f0 - h2 * h2 * f0 + s * s * f1 + 2 * h1 * h2 * fx - h1 * h1 * fx;
        n = n * s;
        n = floor_div(n, 6);
        n = floor_div(n, h1);
        n = floor_div(n, h2);
        n = floor_div(n, FIX_SCALE);
        add_to_sum(n);
      end else if (last && seen >= 3) begin
        h1 = wide_t'(x) - wide_t'(x_hist[1]);
        h2 = wide_t'(x_hist[1]) - wide_t'(x_hist[0]);
        s = h1 + h2;
        n = 2 * h1 * h1 * h2 * fx + 3 * h1 * h2 * h2 * fx + h1 * h1 * s * f1
            + 3 * h1 * h2 * s * f1 - h1 * h1 * h1 * f0;
        n = floor_div(n, 6);
        n = floor_div(n, h2);
        n = floor_div(n, s);
        n = floor_div(n, FIX_SCALE);
        add_to_sum(n);
      end
    end
    x_hist[0] = x_hist[1]; x_hist[1] = x;
    f_hist[0] = f_hist[1]; f_hist[1] = f;
    if (n_seen < 3) n_seen = n_seen + 1;
    odd_pt = ~odd_pt;
    if (last) begin
      if (seen < 2) begin
        r.integral = '0; r.status = sip_pkg::STATUS_FEW;
      end else if (err_code == sip_pkg::STATUS_SPACING) begin
        r.integral = '0; r.status = sip_pkg::STATUS_SPACING;
      end else begin
        r.integral = integ_sum; r.status = err_code;
      end
      expected_q.push_back(r);
      clear_series();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk_i) begin
    integral_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", m_axis_tdata, '0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata !== want.integral)
            report_mismatch("integral", m_axis_tdata, want.integral);
          if (m_axis_tuser !== want.status)
            report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_point(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
      n_pending = expected_q.size();
    end
  end
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  simpson_integrator_nonuniform_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  simpson_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_point(logic [31:0] x, logic [31:0] f, logic last);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {f, x};
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(3))
      0: return $urandom_range(255, 1);
      1: return $urandom_range(65535, 1);
      2: return $urandom_range(32'h03FF_FFFF, 1);
      default: return $urandom_range(32'h0FFF_FFFF, 1);
    endcase
  endfunction

  task automatic random_series(output int sent);
    int len;
    int kind;
    logic [31:0] x;
    len = $urandom_range(8, 1);
    kind = $urandom_range(9);
    x = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(2000)) - 1000) <<< 16;
    for (int i = 0; i < len; i++) begin
      send_point(x, rand_value(), i == len - 1);
      if (kind == 0) x = $urandom;
      else if (kind == 1 && $urandom_range(3) == 0) x = x - $urandom_range(2);
      else x = x + rand_step();
    end
    sent = len;
  endtask

  initial begin
    int sent;
    int total;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_point(32'h0001_0000, 32'h0003_0000, 1'b1);
    send_point(32'h0000_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0002_0000, 1'b1);
    send_point(32'h0000_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0004_0000, 1'b0);
    send_point(32'h0003_0000, 32'hFFFF_0000, 1'b1);
    send_point(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h0000_8000, 32'h8000_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0002_4000, 32'h7FFF_FFFF, 1'b1);
    send_point(32'h0000_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 1'b1);
    send_point(32'h0005_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0006_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0004_0000, 32'h0001_0000, 1'b1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFE, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 60 : (phase == 3) ? 19 : 0;
      recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 19 : 0;
      total = 0;
      while (total < 310) begin
        random_series(sent);
        total += sent;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
